/* hw/rtl/mbmi_pkg.sv */
// Package for the multicart bank mapper with cycle IRQ.
// Request codes, bit positions and the result record; no dependencies.
`timescale 1ns / 1ps

package mbmi_pkg;

    typedef enum logic [1:0] {
        REQ_CPU_WRITE = 2'd0,
        REQ_CPU_TICK  = 2'd1,
        REQ_CPU_READ  = 2'd2,
        REQ_PPU       = 2'd3
    } req_t;

    localparam int BANK8K_SHIFT = 13;
    localparam int IRQ_BIT      = 12;

    // Mode latch bits
    localparam int ML_NORMAL   = 3;
    localparam int ML_32K      = 7;
    localparam int ML_16K      = 6;
    localparam int ML_PRG_B0   = 5;
    localparam int ML_HMIRROR  = 2;

    // Register select bits for the $4000-$5FFF window
    localparam int WA_SEL_ON  = 5;
    localparam int WA_SEL_OFF = 6;
    localparam int WA_IRQ_REG = 8;

    localparam logic [2:0] SLOT_WRAM  = 3'd3;
    localparam logic [2:0] SLOT_8000  = 3'd4;
    localparam logic [2:0] SLOT_A000  = 3'd5;
    localparam logic [2:0] SLOT_C000  = 3'd6;
    localparam logic [2:0] REGION_REG = 3'd2;
    localparam logic [2:0] REGION_ML  = 3'd4;

    typedef struct packed {
        logic [16:0] prg_address;
        logic        prg_selected;
        logic [14:0] chr_address;
        logic        ciram_a10;
        logic        irq_active;
    } result_t;

endpackage

/* hw/rtl/multicart_bank_mapper_irq.sv */
// Multicart bank mapper: CPU register writes, cycle IRQ counter, PRG/CHR translation.
// Each accepted request passes through the input register, then one combinational pass into
// the result register; one transaction per cycle sustained while out_stall is low.
// Uses mbmi_pkg. Reset (rst_n, async, active low) clears the mode latch, game bank,
// IRQ enable, cycle counter, IRQ line and both valid flags.
`timescale 1ns / 1ps

module multicart_bank_mapper_irq
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  mbmi_pkg::req_t       req_type,
    input  logic [15:0]          address,
    input  logic [7:0]           write_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [16:0]          prg_address,
    output logic                 prg_selected,
    output logic [14:0]          chr_address,
    output logic                 ciram_a10,
    output logic                 irq_active
);
    import mbmi_pkg::*;

    logic        s1_valid_reg;
    req_t        s1_req_reg;
    logic [15:0] s1_addr_reg;
    logic [7:0]  s1_data_reg;
    logic        s1_advance;

    logic        out_valid_reg;
    result_t     out_reg;
    result_t     out_next;

    logic [7:0]  mode_latch_reg;
    logic [7:0]  mode_latch_next;
    logic [3:0]  game_bank_reg;
    logic [3:0]  game_bank_next;
    logic        irq_enable_reg;
    logic        irq_enable_next;
    logic [15:0] cycle_counter_reg;
    logic [15:0] cycle_counter_next;
    logic        irq_line_reg;
    logic        irq_line_next;

    logic [2:0]  slot;
    logic [2:0]  prg_bank16;
    logic [3:0]  prg_bank8;
    logic [15:0] counter_inc;

    assign s1_advance = !out_valid_reg || !out_stall;
    assign in_stall   = s1_valid_reg && !s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_req_reg  <= req_type;
            s1_addr_reg <= address;
            s1_data_reg <= write_data;
        end
    end

    assign slot        = s1_addr_reg[15:13];
    assign prg_bank16  = {mode_latch_reg[ML_NORMAL], mode_latch_reg[ML_32K],
                          mode_latch_reg[ML_PRG_B0]};
    assign counter_inc = 16'(cycle_counter_reg + 16'd1);

    always_comb
    begin
        if (slot == SLOT_WRAM)
        begin
            prg_bank8 = 4'd7;
        end
        else if (mode_latch_reg[ML_NORMAL])
        begin
            if (mode_latch_reg[ML_32K])
            begin
                prg_bank8 = {prg_bank16[2:1], slot[1:0]};
            end
            else if (mode_latch_reg[ML_16K])
            begin
                prg_bank8 = {prg_bank16, slot[0]};
            end
            else
            begin
                prg_bank8 = {prg_bank16, 1'b0};
            end
        end
        else
        begin
            case (slot)
                SLOT_8000: prg_bank8 = 4'd0;
                SLOT_A000: prg_bank8 = 4'd1;
                SLOT_C000: prg_bank8 = {game_bank_reg[3], game_bank_reg[0],
                                        game_bank_reg[2:1]};
                default:   prg_bank8 = 4'd3;
            endcase
        end
    end

    always_comb
    begin
        mode_latch_next    = mode_latch_reg;
        game_bank_next     = game_bank_reg;
        irq_enable_next    = irq_enable_reg;
        cycle_counter_next = cycle_counter_reg;
        irq_line_next      = irq_line_reg;
        out_next           = '0;

        unique case (s1_req_reg)
            REQ_CPU_WRITE:
            begin
                if (slot == REGION_ML)
                begin
                    mode_latch_next = s1_data_reg;
                end
                else if (slot == REGION_REG && s1_addr_reg[WA_SEL_ON]
                         && !s1_addr_reg[WA_SEL_OFF])
                begin
                    if (s1_addr_reg[WA_IRQ_REG])
                    begin
                        irq_enable_next = s1_data_reg[0];
                    end
                    else
                    begin
                        game_bank_next = s1_data_reg[3:0];
                    end
                end
            end
            REQ_CPU_TICK:
            begin
                if (irq_enable_reg)
                begin
                    cycle_counter_next = counter_inc;
                    irq_line_next      = counter_inc[IRQ_BIT];
                end
                else
                begin
                    cycle_counter_next = '0;
                    irq_line_next      = 1'b0;
                end
            end
            REQ_CPU_READ:
            begin
                if (s1_addr_reg[15] || (s1_addr_reg[14] && s1_addr_reg[13]))
                begin
                    out_next.prg_selected = 1'b1;
                    out_next.prg_address  = {prg_bank8, s1_addr_reg[BANK8K_SHIFT-1:0]};
                end
            end
            REQ_PPU:
            begin
                if (!s1_addr_reg[13])
                begin
                    out_next.chr_address = {mode_latch_reg[2:1],
                                            s1_addr_reg[BANK8K_SHIFT-1:0]};
                end
                out_next.ciram_a10 = mode_latch_reg[ML_HMIRROR] ? s1_addr_reg[11]
                                                                : s1_addr_reg[10];
            end
            default:
            begin
            end
        endcase

        out_next.irq_active = irq_line_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_latch_reg    <= '0;
            game_bank_reg     <= '0;
            irq_enable_reg    <= 1'b0;
            cycle_counter_reg <= '0;
            irq_line_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                mode_latch_reg    <= mode_latch_next;
                game_bank_reg     <= game_bank_next;
                irq_enable_reg    <= irq_enable_next;
                cycle_counter_reg <= cycle_counter_next;
                irq_line_reg      <= irq_line_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign prg_address  = out_reg.prg_address;
    assign prg_selected = out_reg.prg_selected;
    assign chr_address  = out_reg.chr_address;
    assign ciram_a10    = out_reg.ciram_a10;
    assign irq_active   = out_reg.irq_active;

endmodule

/* hw/rtl/mbmi_checker.sv */
// Port-level checks for multicart_bank_mapper_irq, bound to the top level.
// Uses mbmi_pkg for the request type.
`timescale 1ns / 1ps

module mbmi_checker
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  mbmi_pkg::req_t       req_type,
    input  logic [15:0]          address,
    input  logic [7:0]           write_data,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [16:0]          prg_address,
    input  logic                 prg_selected,
    input  logic [14:0]          chr_address,
    input  logic                 ciram_a10,
    input  logic                 irq_active
);
    import mbmi_pkg::*;

    // Hold a stalled result transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(prg_address)
            && $stable(prg_selected) && $stable(chr_address)
            && $stable(ciram_a10) && $stable(irq_active))
        else $error("stalled result changed");

    // Hold a stalled request transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(req_type)
            && $stable(address) && $stable(write_data))
        else $error("stalled request changed");

    // Input backpressure only comes from a stalled full output.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // PRG and PPU results are exclusive.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && prg_selected |-> chr_address == '0 && !ciram_a10)
        else $error("PRG and PPU fields both set");

    // Unselected PRG address reads zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !prg_selected |-> prg_address == '0)
        else $error("PRG address set without selection");

endmodule

bind multicart_bank_mapper_irq mbmi_checker u_mbmi_checker (.*);
